// ----- rtl/core/lbt_pkg.sv -----
// ----------------------------------------------------------------------------
// LED blink timer package
// Item types, mode codes and widths shared by the LED blink timer modules.
// ----------------------------------------------------------------------------
package lbt_pkg;

    localparam int TIME_BITS   = 32;
    localparam int REPEAT_BITS = 16;
    localparam int TOGGLE_BITS = REPEAT_BITS + 1;

    localparam logic [TIME_BITS-1:0] DEFAULT_HALF_PERIOD = TIME_BITS'(500);

    localparam logic [2:0] MODE_TICK    = 3'd0;
    localparam logic [2:0] MODE_ON      = 3'd1;
    localparam logic [2:0] MODE_OFF     = 3'd2;
    localparam logic [2:0] MODE_TOGGLE  = 3'd3;
    localparam logic [2:0] MODE_LEVEL   = 3'd4;
    localparam logic [2:0] MODE_TIMED   = 3'd5;
    localparam logic [2:0] MODE_BLINK   = 3'd6;
    localparam logic [2:0] MODE_COUNTED = 3'd7;

    typedef struct packed {
        logic [2:0]             mode;
        logic                   level;
        logic [TIME_BITS-1:0]   duration_ms;
        logic [TIME_BITS-1:0]   half_period_ms;
        logic [REPEAT_BITS-1:0] repeat_count;
    } t_in_item;

    typedef struct packed {
        logic led_level;
        logic blinking;
        logic timed_on_active;
    } t_out_item;

endpackage

// ----- rtl/core/lbt_state.sv -----
// ----------------------------------------------------------------------------
// LED blink timer state
// Holds the LED, blink and timed-on state and applies one item per cycle while i_advance is high.
// ----------------------------------------------------------------------------
module lbt_state
    import lbt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_advance,
    input  t_in_item  i_item,
    output t_out_item o_result
);

    logic                   r_lit,          n_lit;
    logic                   r_blink,        n_blink;
    logic                   r_timer,        n_timer;
    logic [TIME_BITS-1:0]   r_on_left,      n_on_left;
    logic [TIME_BITS-1:0]   r_since,        n_since;
    logic [TIME_BITS-1:0]   r_interval,     n_interval;
    logic [TOGGLE_BITS-1:0] r_toggles_left, n_toggles_left;

    logic [TIME_BITS-1:0]   since_inc;
    logic [TIME_BITS-1:0]   on_dec;
    logic [TIME_BITS-1:0]   blink_interval;

    assign since_inc      = r_since + TIME_BITS'(1);
    assign on_dec         = (r_on_left != '0) ? (r_on_left - TIME_BITS'(1)) : r_on_left;
    // A zero half period selects the default.
    assign blink_interval = (i_item.half_period_ms == '0) ? DEFAULT_HALF_PERIOD
                                                          : i_item.half_period_ms;

    always_comb begin
        n_lit          = r_lit;
        n_blink        = r_blink;
        n_timer        = r_timer;
        n_on_left      = r_on_left;
        n_since        = r_since;
        n_interval     = r_interval;
        n_toggles_left = r_toggles_left;
        case (i_item.mode)
            MODE_TICK: begin
                if (r_timer) begin
                    n_on_left = on_dec;
                    if (on_dec == '0) begin
                        n_lit   = 1'b0;
                        n_timer = 1'b0;
                    end
                end
                if (r_blink) begin
                    n_since = since_inc;
                    if (since_inc >= r_interval) begin
                        n_lit   = ~n_lit;
                        n_since = '0;
                        if (r_toggles_left != '0) begin
                            n_toggles_left = r_toggles_left - TOGGLE_BITS'(1);
                            if (r_toggles_left == TOGGLE_BITS'(1)) begin
                                n_blink = 1'b0;
                                n_lit   = 1'b0;
                            end
                        end
                    end
                end
            end
            MODE_ON, MODE_OFF, MODE_TOGGLE, MODE_LEVEL: begin
                case (i_item.mode)
                    MODE_ON:     n_lit = 1'b1;
                    MODE_OFF:    n_lit = 1'b0;
                    MODE_TOGGLE: n_lit = ~r_lit;
                    default:     n_lit = i_item.level;
                endcase
                n_blink = 1'b0;
                n_timer = 1'b0;
            end
            MODE_TIMED: begin
                n_blink   = 1'b0;
                n_on_left = i_item.duration_ms;
                n_lit     = (i_item.duration_ms != '0);
                n_timer   = (i_item.duration_ms != '0);
            end
            MODE_BLINK, MODE_COUNTED: begin
                n_interval = blink_interval;
                n_since    = '0;
                n_blink    = 1'b1;
                n_timer    = 1'b0;
                n_lit      = 1'b1;
                // The plain blink command keeps any leftover toggle count.
                if (i_item.mode == MODE_COUNTED) begin
                    n_toggles_left = {i_item.repeat_count, 1'b0};
                end
            end
            default: begin
                n_lit = r_lit;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lit          <= 1'b0;
            r_blink        <= 1'b0;
            r_timer        <= 1'b0;
            r_on_left      <= '0;
            r_since        <= '0;
            r_interval     <= '0;
            r_toggles_left <= '0;
        end else if (i_advance) begin
            r_lit          <= n_lit;
            r_blink        <= n_blink;
            r_timer        <= n_timer;
            r_on_left      <= n_on_left;
            r_since        <= n_since;
            r_interval     <= n_interval;
            r_toggles_left <= n_toggles_left;
        end
    end

    assign o_result.led_level       = n_lit;
    assign o_result.blinking        = n_blink;
    assign o_result.timed_on_active = n_timer;

endmodule

// ----- rtl/core/led_blink_timer_controller.sv -----
// ----------------------------------------------------------------------------
// LED blink timer controller
// Drives one LED level from command items and one-millisecond tick items.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake                      | Payload     | Direction
//  --------+--------------------------------+-------------+----------
//  in      | i_in_valid / o_in_ready        | i_in_item   | into block
//  out     | o_out_valid / i_out_ready      | o_out_item  | out of block
//
// Every accepted item, tick or command, produces exactly one result item,
// which carries the LED level and the blink and timed-on flags after that
// item. The state update is one short add-and-compare step, so one item is
// taken every cycle unless the input is stalled; its result is registered.
// A synchronous active-low reset clears the LED state and empties the output.
// The output side has a result register plus a skid register, so the block
// keeps taking items while a result waits; it stalls its input only when
// both hold a result that has not been taken.
//
module led_blink_timer_controller
    import lbt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic      accept;
    logic      taken;
    t_out_item result;

    logic      r_out_valid;
    t_out_item r_out;
    logic      r_skid_valid;
    t_out_item r_skid;

    // The input is open whenever the skid register is free.
    assign o_in_ready = ~r_skid_valid;
    assign accept     = i_in_valid & o_in_ready;
    assign taken      = r_out_valid & i_out_ready;

    // State update for the accepted item; the result is the state after it.
    lbt_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_advance(accept),
        .i_item   (i_in_item),
        .o_result (result)
    );

    // Output control: the skid result goes ahead of a new one, so order holds.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (taken || !r_out_valid) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= accept;
                end
            end else if (accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // Result payloads carry no reset.
    always_ff @(posedge i_clk) begin
        if (taken || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept) begin
                r_out <= result;
            end
        end else if (accept) begin
            r_skid <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef ASSERT_OFF
    // A held skid result always sits behind a result in the output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result while the output is empty");

    // Blinking and the timed-on countdown exclude each other.
    a_modes_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.blinking && o_out_item.timed_on_active))
        else $error("blinking and timed-on reported together");

    // While the timed-on countdown runs, the LED is lit.
    a_timed_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.timed_on_active) |-> o_out_item.led_level)
        else $error("timed-on active with the LED dark");

    // An item accepted with no result pending shows up on the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !r_out_valid) |=> o_out_valid)
        else $error("result missing after an accepted item");
`endif

endmodule
